### src/rcm_pkg.sv
package rcm_pkg;

  // Channel count and fixed channel roles
  localparam int NUM_CHANNELS = 4;
  localparam logic [1:0] CH_ROLL   = 2'd0;
  localparam logic [1:0] CH_PITCH  = 2'd1;
  localparam logic [1:0] CH_THRUST = 2'd2;
  localparam logic [1:0] CH_YAW    = 2'd3;

  // Item opcodes; the fourth code does nothing
  typedef enum logic [1:0] {
    OP_EDGE = 2'd0,
    OP_CMD  = 2'd1,
    OP_EVAL = 2'd2
  } opcode_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TIMEOUT  = 2'd0,
    REG_CENTER   = 2'd1,
    REG_DEADBAND = 2'd2,
    REG_FAILSAFE = 2'd3
  } reg_idx_t;

  // Reset values
  localparam logic [31:0] TIMEOUT_RST  = 32'd500000;
  localparam logic [15:0] CENTER_RST   = 16'd1500;
  localparam logic [15:0] DEADBAND_RST = 16'd50;
  localparam logic [15:0] FAILSAFE_RST = 16'd900;
  localparam logic [15:0] DRIVE_RST    = 16'd1500;

  // Host command pre-scaled to a quotient numerator (width / 5 or / 125 remains)
  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  channel;
    logic        level;
    logic [31:0] now_us;
    logic [13:0] roll_q;
    logic [13:0] pitch_q;
    logic [13:0] yaw_q;
    logic [17:0] thrust_q;
  } item_t;

  // One result: drive widths and failsafe status
  typedef struct packed {
    logic [NUM_CHANNELS-1:0][15:0] drive;
    logic                          failsafe;
  } result_t;

endpackage

### src/rcm_if.sv
// Input item channel
interface rcm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [1:0]         channel;
  logic               level;
  logic [31:0]        now_us;
  logic signed [15:0] roll_cmd;
  logic signed [15:0] pitch_cmd;
  logic signed [15:0] yaw_rate_cmd;
  logic [15:0]        thrust_cmd;

  modport source (
    output valid, opcode, channel, level, now_us,
    output roll_cmd, pitch_cmd, yaw_rate_cmd, thrust_cmd,
    input  ready
  );
  modport sink (
    input  valid, opcode, channel, level, now_us,
    input  roll_cmd, pitch_cmd, yaw_rate_cmd, thrust_cmd,
    output ready
  );
endinterface

// Result channel
interface rcm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] roll_out;
  logic [15:0] pitch_out;
  logic [15:0] thrust_out;
  logic [15:0] yaw_out;
  logic        failsafe_active;

  modport source (
    output valid, roll_out, pitch_out, thrust_out, yaw_out, failsafe_active,
    input  ready
  );
  modport sink (
    input  valid, roll_out, pitch_out, thrust_out, yaw_out, failsafe_active,
    output ready
  );
endinterface

### src/rc_pulse_capture_command_mixer.sv
// RC pulse capture and host/RC command mixer. Takes one item per clock sustained
// while results are taken without stall: an item is registered into the input
// register on transfer, applied to the capture/host/mix state as it moves into
// the result register, and its result is offered from the result register. The
// input register and the result register form a two-entry pipe, so an input
// transfer can still be taken while a result waits. Every item, including the
// unused opcode, yields one result with the four drive widths and the failsafe
// status after that item. Configuration writes take effect on the next clock edge;
// the user must make them while no item is in flight; the block does not check.
module rc_pulse_capture_command_mixer (
  input  logic        clk,
  input  logic        rst_n,
  rcm_in_if.sink      in_ch,
  rcm_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  rcm_pkg::item_t   item_nxt, item_r;
  rcm_pkg::result_t res_nxt, res_r;
  logic             v1_r, vo_r;
  logic             adv1;

  // Host command scaling ahead of the input register
  rcm_cmd_prep u_prep (
    .roll_cmd     (in_ch.roll_cmd),
    .pitch_cmd    (in_ch.pitch_cmd),
    .yaw_rate_cmd (in_ch.yaw_rate_cmd),
    .thrust_cmd   (in_ch.thrust_cmd),
    .roll_q       (item_nxt.roll_q),
    .pitch_q      (item_nxt.pitch_q),
    .yaw_q        (item_nxt.yaw_q),
    .thrust_q     (item_nxt.thrust_q)
  );

  assign item_nxt.opcode  = in_ch.opcode;
  assign item_nxt.channel = in_ch.channel;
  assign item_nxt.level   = in_ch.level;
  assign item_nxt.now_us  = in_ch.now_us;

  // Handshake: item moves on when the result register is free or draining
  assign adv1        = v1_r && (!vo_r || out_ch.ready);
  assign in_ch.ready = !v1_r || adv1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_ch.ready) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r <= item_nxt;
    end
  end

  // State and mixing
  rcm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (adv1),
    .item      (item_r),
    .res       (res_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (adv1) begin
      vo_r <= 1'b1;
    end else if (out_ch.ready) begin
      vo_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = vo_r;
  assign out_ch.roll_out        = res_r.drive[rcm_pkg::CH_ROLL];
  assign out_ch.pitch_out       = res_r.drive[rcm_pkg::CH_PITCH];
  assign out_ch.thrust_out      = res_r.drive[rcm_pkg::CH_THRUST];
  assign out_ch.yaw_out         = res_r.drive[rcm_pkg::CH_YAW];
  assign out_ch.failsafe_active = res_r.failsafe;

`ifndef ASSERT_OFF
  // An item leaving the input register always lands in the result register
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv1 |=> vo_r)
    else $error("advanced item lost");

  // Both stages full and result stalled: no input transfer
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && vo_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while pipe full");
`endif

endmodule

### src/rcm_cmd_prep.sv
// Clamps the host command and forms the scaled numerators ahead of the input register.
// Roll/pitch/yaw: (1500*40960 +/- v*gain) >> 13, still to be divided by 5.
// Thrust: (1200*256000 + t*8108) >> 11, still to be divided by 125.
module rcm_cmd_prep (
  input  logic signed [15:0] roll_cmd,
  input  logic signed [15:0] pitch_cmd,
  input  logic signed [15:0] yaw_rate_cmd,
  input  logic [15:0]        thrust_cmd,
  output logic [13:0]        roll_q,
  output logic [13:0]        pitch_q,
  output logic [13:0]        yaw_q,
  output logic [17:0]        thrust_q
);

  localparam logic signed [15:0] ANGLE_LIM   = 16'sd1072;
  localparam logic signed [15:0] YAW_LIM     = 16'sd3216;
  localparam logic [15:0]        THRUST_LO   = 16'd5120;
  localparam logic [15:0]        THRUST_HI   = 16'd12800;
  localparam logic signed [30:0] ANGLE_BIAS  = 31'sd61440000;
  localparam logic signed [30:0] ANGLE_GAIN  = 31'sd5729;
  localparam logic signed [30:0] YAW_GAIN    = 31'sd1592;
  localparam logic [28:0]        THRUST_BIAS = 29'd307200000;
  localparam logic [28:0]        THRUST_GAIN = 29'd8108;

  logic signed [15:0] roll_c, pitch_c, yaw_c;
  logic [15:0]        thrust_c;
  logic signed [30:0] roll_n, pitch_n, yaw_n;
  logic [28:0]        thrust_n;

  // Saturation
  always_comb begin
    roll_c = roll_cmd;
    if (roll_cmd > ANGLE_LIM) roll_c = ANGLE_LIM;
    else if (roll_cmd < -ANGLE_LIM) roll_c = -ANGLE_LIM;
    pitch_c = pitch_cmd;
    if (pitch_cmd > ANGLE_LIM) pitch_c = ANGLE_LIM;
    else if (pitch_cmd < -ANGLE_LIM) pitch_c = -ANGLE_LIM;
    yaw_c = yaw_rate_cmd;
    if (yaw_rate_cmd > YAW_LIM) yaw_c = YAW_LIM;
    else if (yaw_rate_cmd < -YAW_LIM) yaw_c = -YAW_LIM;
    thrust_c = thrust_cmd;
    if (thrust_cmd < THRUST_LO) thrust_c = THRUST_LO;
    else if (thrust_cmd > THRUST_HI) thrust_c = THRUST_HI;
  end

  // Constant gains; all numerators stay positive
  assign roll_n   = ANGLE_BIAS + 31'(roll_c) * ANGLE_GAIN;
  assign pitch_n  = ANGLE_BIAS - 31'(pitch_c) * ANGLE_GAIN;
  assign yaw_n    = ANGLE_BIAS + 31'(yaw_c) * YAW_GAIN;
  assign thrust_n = THRUST_BIAS + 29'(thrust_c) * THRUST_GAIN;

  // Power-of-two part of the divisor
  assign roll_q   = roll_n[26:13];
  assign pitch_q  = pitch_n[26:13];
  assign yaw_q    = yaw_n[26:13];
  assign thrust_q = thrust_n[28:11];

endmodule

### src/rcm_core.sv
// Capture, host and mix state; gives the post-item view of the outputs.
module rcm_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_wdata,
  input  logic             fire,
  input  rcm_pkg::item_t   item,
  output rcm_pkg::result_t res
);

  localparam int N = rcm_pkg::NUM_CHANNELS;
  // Reciprocals: exact over the numerator ranges in use
  localparam logic [30:0] RECIP5   = 31'd52429;
  localparam int          SHIFT5   = 18;
  localparam logic [36:0] RECIP125 = 37'd268436;
  localparam int          SHIFT125 = 25;

  logic [31:0] timeout_r;
  logic [15:0] center_r, deadband_r, failsafe_r;

  logic [N-1:0][31:0] rise_r, rise_nxt;
  logic [N-1:0][15:0] rcw_r, rcw_nxt;
  logic [N-1:0][15:0] host_r, host_nxt;
  logic [N-1:0][15:0] drive_r, drive_nxt;
  logic [31:0]        last_cmd_r, last_cmd_nxt;
  logic [N-1:0]       fresh_r, fresh_nxt;
  logic               tout_r, tout_nxt;

  logic [30:0]        roll_prod, pitch_prod, yaw_prod;
  logic [36:0]        thr_prod;
  logic [N-1:0][15:0] host_calc;
  logic [31:0]        pulse;
  logic [31:0]        elapsed;
  logic               tout_eval;
  logic [N-1:0]       outside;
  logic [N-1:0][15:0] want;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= rcm_pkg::TIMEOUT_RST;
      center_r   <= rcm_pkg::CENTER_RST;
      deadband_r <= rcm_pkg::DEADBAND_RST;
      failsafe_r <= rcm_pkg::FAILSAFE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcm_pkg::REG_TIMEOUT:  timeout_r  <= cfg_wdata;
        rcm_pkg::REG_CENTER:   center_r   <= cfg_wdata[15:0];
        rcm_pkg::REG_DEADBAND: deadband_r <= cfg_wdata[15:0];
        rcm_pkg::REG_FAILSAFE: failsafe_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Remaining divide by 5 / 125 of the host widths
  assign roll_prod  = 31'(item.roll_q) * RECIP5;
  assign pitch_prod = 31'(item.pitch_q) * RECIP5;
  assign yaw_prod   = 31'(item.yaw_q) * RECIP5;
  assign thr_prod   = 37'(item.thrust_q) * RECIP125;
  assign host_calc[rcm_pkg::CH_ROLL]   = 16'(roll_prod >> SHIFT5);
  assign host_calc[rcm_pkg::CH_PITCH]  = 16'(pitch_prod >> SHIFT5);
  assign host_calc[rcm_pkg::CH_YAW]    = 16'(yaw_prod >> SHIFT5);
  assign host_calc[rcm_pkg::CH_THRUST] = 16'(thr_prod >> SHIFT125);

  // Pulse width and timeout check
  assign pulse     = item.now_us - rise_r[item.channel];
  assign elapsed   = item.now_us - last_cmd_r;
  assign tout_eval = elapsed > timeout_r;

  // Mix selection per channel
  always_comb begin
    logic [16:0] diff;
    logic [16:0] mag;
    for (int i = 0; i < N; i++) begin
      diff = {1'b0, rcw_r[i]} - {1'b0, center_r};
      mag  = diff[16] ? (17'd0 - diff) : diff;
      outside[i] = mag > {1'b0, deadband_r};
      want[i] = outside[i] ? rcw_r[i] : host_r[i];
    end
    want[rcm_pkg::CH_THRUST] = (rcw_r[rcm_pkg::CH_THRUST] < host_r[rcm_pkg::CH_THRUST]) ?
                               rcw_r[rcm_pkg::CH_THRUST] : host_r[rcm_pkg::CH_THRUST];
    if (tout_eval) begin
      for (int i = 0; i < N; i++) want[i] = failsafe_r;
    end
  end

  // Next state for the item leaving the input register
  always_comb begin
    rise_nxt     = rise_r;
    rcw_nxt      = rcw_r;
    host_nxt     = host_r;
    drive_nxt    = drive_r;
    last_cmd_nxt = last_cmd_r;
    fresh_nxt    = fresh_r;
    tout_nxt     = tout_r;
    if (fire) begin
      unique case (item.opcode)
        rcm_pkg::OP_EDGE: begin
          if (item.level) begin
            rise_nxt[item.channel] = item.now_us;
          end else begin
            rcw_nxt[item.channel]   = pulse[15:0];
            fresh_nxt[item.channel] = 1'b1;
          end
        end
        rcm_pkg::OP_CMD: begin
          host_nxt     = host_calc;
          last_cmd_nxt = item.now_us;
        end
        rcm_pkg::OP_EVAL: begin
          tout_nxt = tout_eval;
          for (int i = 0; i < N; i++) begin
            if (fresh_r[i]) drive_nxt[i] = want[i];
          end
          fresh_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r     <= '0;
      rcw_r      <= '0;
      host_r     <= '0;
      last_cmd_r <= '0;
      fresh_r    <= '0;
      tout_r     <= 1'b0;
      for (int i = 0; i < N; i++) drive_r[i] <= rcm_pkg::DRIVE_RST;
    end else begin
      rise_r     <= rise_nxt;
      rcw_r      <= rcw_nxt;
      host_r     <= host_nxt;
      last_cmd_r <= last_cmd_nxt;
      fresh_r    <= fresh_nxt;
      tout_r     <= tout_nxt;
      drive_r    <= drive_nxt;
    end
  end

  assign res.drive    = drive_nxt;
  assign res.failsafe = tout_nxt;

`ifndef ASSERT_OFF
  // An evaluate clears every fresh flag
  a_eval_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.opcode == rcm_pkg::OP_EVAL |=> fresh_r == '0)
    else $error("fresh flags not cleared by evaluate");

  // Failsafe status only moves on an evaluate
  a_tout_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && item.opcode == rcm_pkg::OP_EVAL) |=> $stable(tout_r))
    else $error("failsafe status changed outside evaluate");
`endif

endmodule

### tb/sv/tb_rc_pulse_capture_command_mixer.sv
`timescale 1ns / 100ps

module tb_rc_pulse_capture_command_mixer;

  // Opcode with no effect on the block
  localparam logic [1:0] OP_IDLE_CODE = 2'd3;

  // Host command saturation limits
  localparam int ANGLE_LIM  = 1072;
  localparam int YAW_LIM    = 3216;
  localparam int THRUST_MIN = 5120;
  localparam int THRUST_MAX = 12800;

  localparam int PHASE_ITEMS = 130;

  typedef struct {
    logic [1:0]         opcode;
    logic [1:0]         channel;
    logic               level;
    logic [31:0]        now_us;
    logic signed [15:0] roll_cmd;
    logic signed [15:0] pitch_cmd;
    logic signed [15:0] yaw_rate_cmd;
    logic [15:0]        thrust_cmd;
  } pulse_item_t;

  typedef struct packed {
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] thrust;
    logic [15:0] yaw;
    logic        failsafe;
  } drive_set_t;

  // Predicts the drive widths after each item and checks them in order
  class mixer_predictor;
    logic [31:0]                     timeout_us;
    logic [15:0]                     center;
    logic [15:0]                     deadband;
    logic [15:0]                     failsafe_w;
    logic [31:0]                     rise_at [rcm_pkg::NUM_CHANNELS];
    logic [15:0]                     rc_w [rcm_pkg::NUM_CHANNELS];
    logic [15:0]                     host_w [rcm_pkg::NUM_CHANNELS];
    logic [15:0]                     drive_w [rcm_pkg::NUM_CHANNELS];
    logic [31:0]                     last_cmd_us;
    logic [rcm_pkg::NUM_CHANNELS-1:0] fresh;
    logic                            timed_out;
    drive_set_t                      awaited_drives [$];
    int                              failures;

    function new();
      int i;
      timeout_us = rcm_pkg::TIMEOUT_RST;
      center     = rcm_pkg::CENTER_RST;
      deadband   = rcm_pkg::DEADBAND_RST;
      failsafe_w = rcm_pkg::FAILSAFE_RST;
      for (i = 0; i < rcm_pkg::NUM_CHANNELS; i++) begin
        rise_at[i] = '0;
        rc_w[i]    = '0;
        host_w[i]  = '0;
        drive_w[i] = rcm_pkg::DRIVE_RST;
      end
      last_cmd_us = '0;
      fresh       = '0;
      timed_out   = 1'b0;
      failures    = 0;
    endfunction

    function void write_reg(rcm_pkg::reg_idx_t idx, logic [31:0] data);
      case (idx)
        rcm_pkg::REG_TIMEOUT:  timeout_us = data;
        rcm_pkg::REG_CENTER:   center     = data[15:0];
        rcm_pkg::REG_DEADBAND: deadband   = data[15:0];
        rcm_pkg::REG_FAILSAFE: failsafe_w = data[15:0];
        default: ;
      endcase
    endfunction

    function int clamp(int v, int lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // RC wins only when it lies outside the deadband around centre
    function logic [15:0] pick_width(int ch);
      int dev;
      dev = int'(rc_w[ch]) - int'(center);
      if (dev < 0) dev = -dev;
      return (dev > int'(deadband)) ? rc_w[ch] : host_w[ch];
    endfunction

    function void note_item(pulse_item_t it);
      logic [15:0] want [rcm_pkg::NUM_CHANNELS];
      logic [31:0] span;
      int          r, p, y, t, i;
      drive_set_t  d;
      case (it.opcode)
        rcm_pkg::OP_EDGE: begin
          if (it.level) begin
            rise_at[it.channel] = it.now_us;
          end else begin
            span = it.now_us - rise_at[it.channel];
            rc_w[it.channel]  = span[15:0];
            fresh[it.channel] = 1'b1;
          end
        end
        rcm_pkg::OP_CMD: begin
          r = clamp(it.roll_cmd, ANGLE_LIM);
          p = clamp(it.pitch_cmd, ANGLE_LIM);
          y = clamp(it.yaw_rate_cmd, YAW_LIM);
          t = it.thrust_cmd;
          if (t < THRUST_MIN) t = THRUST_MIN;
          if (t > THRUST_MAX) t = THRUST_MAX;
          host_w[rcm_pkg::CH_ROLL]   = 16'((1500 * 40960 + r * 5729) / 40960);
          host_w[rcm_pkg::CH_PITCH]  = 16'((1500 * 40960 - p * 5729) / 40960);
          host_w[rcm_pkg::CH_THRUST] = 16'((1200 * 256000 + t * 8108) / 256000);
          host_w[rcm_pkg::CH_YAW]    = 16'((1500 * 40960 + y * 1592) / 40960);
          last_cmd_us = it.now_us;
        end
        rcm_pkg::OP_EVAL: begin
          span = it.now_us - last_cmd_us;
          timed_out = (span > timeout_us);
          if (timed_out) begin
            for (i = 0; i < rcm_pkg::NUM_CHANNELS; i++) want[i] = failsafe_w;
          end else begin
            want[rcm_pkg::CH_ROLL]   = pick_width(rcm_pkg::CH_ROLL);
            want[rcm_pkg::CH_PITCH]  = pick_width(rcm_pkg::CH_PITCH);
            want[rcm_pkg::CH_YAW]    = pick_width(rcm_pkg::CH_YAW);
            want[rcm_pkg::CH_THRUST] =
                (rc_w[rcm_pkg::CH_THRUST] < host_w[rcm_pkg::CH_THRUST]) ?
                rc_w[rcm_pkg::CH_THRUST] : host_w[rcm_pkg::CH_THRUST];
          end
          for (i = 0; i < rcm_pkg::NUM_CHANNELS; i++)
            if (fresh[i]) drive_w[i] = want[i];
          fresh = '0;
        end
        default: ;
      endcase
      d.roll     = drive_w[rcm_pkg::CH_ROLL];
      d.pitch    = drive_w[rcm_pkg::CH_PITCH];
      d.thrust   = drive_w[rcm_pkg::CH_THRUST];
      d.yaw      = drive_w[rcm_pkg::CH_YAW];
      d.failsafe = timed_out;
      awaited_drives.push_back(d);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_drives(drive_set_t got);
      drive_set_t want;
      if (awaited_drives.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = awaited_drives.pop_front();
      compare_field("roll_out", want.roll, got.roll);
      compare_field("pitch_out", want.pitch, got.pitch);
      compare_field("thrust_out", want.thrust, got.thrust);
      compare_field("yaw_out", want.yaw, got.yaw);
      compare_field("failsafe_active", 16'(want.failsafe), 16'(got.failsafe));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  rcm_in_if  in_if ();
  rcm_out_if out_if ();

  rc_pulse_capture_command_mixer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mixer_predictor model = new();

  // Stimulus state shared between the driving tasks and the result sink
  logic        send_idle = 1'b1;
  logic        recv_idle = 1'b1;
  int          hold_cycles = 0;
  int          sent = 0;
  logic [31:0] stamp = '0;
  logic [31:0] cmd_stamp = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Item with every field random; callers overwrite what they need
  function automatic pulse_item_t noise_item();
    pulse_item_t it;
    it.opcode       = 2'($urandom_range(0, 3));
    it.channel      = 2'($urandom_range(0, 3));
    it.level        = 1'($urandom_range(0, 1));
    it.now_us       = $urandom;
    it.roll_cmd     = 16'($urandom);
    it.pitch_cmd    = 16'($urandom);
    it.yaw_rate_cmd = 16'($urandom);
    it.thrust_cmd   = 16'($urandom);
    return it;
  endfunction

  // Leaves valid high after the transfer; the next call replaces or lowers it, or drain() lowers it
  task automatic send_item(input pulse_item_t it);
    int gap;
    gap = send_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.opcode       <= it.opcode;
    in_if.channel      <= it.channel;
    in_if.level        <= it.level;
    in_if.now_us       <= it.now_us;
    in_if.roll_cmd     <= it.roll_cmd;
    in_if.pitch_cmd    <= it.pitch_cmd;
    in_if.yaw_rate_cmd <= it.yaw_rate_cmd;
    in_if.thrust_cmd   <= it.thrust_cmd;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    model.note_item(it);
    sent++;
  endtask

  task automatic send_edge(input logic [1:0] ch, input logic level, input logic [31:0] at);
    pulse_item_t it;
    it = noise_item();
    it.opcode  = rcm_pkg::OP_EDGE;
    it.channel = ch;
    it.level   = level;
    it.now_us  = at;
    send_item(it);
  endtask

  task automatic pulse(input logic [1:0] ch, input logic [31:0] start, input logic [31:0] span);
    send_edge(ch, 1'b1, start);
    send_edge(ch, 1'b0, start + span);
  endtask

  task automatic send_cmd(input logic [31:0] at, input logic [15:0] r, input logic [15:0] p,
                          input logic [15:0] y, input logic [15:0] t);
    pulse_item_t it;
    it = noise_item();
    it.opcode       = rcm_pkg::OP_CMD;
    it.now_us       = at;
    it.roll_cmd     = r;
    it.pitch_cmd    = p;
    it.yaw_rate_cmd = y;
    it.thrust_cmd   = t;
    cmd_stamp = at;
    send_item(it);
  endtask

  task automatic send_eval(input logic [31:0] at);
    pulse_item_t it;
    it = noise_item();
    it.opcode = rcm_pkg::OP_EVAL;
    it.now_us = at;
    send_item(it);
  endtask

  // Stop offering and wait until every awaited result has arrived
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (model.awaited_drives.size() != 0);
  endtask

  task automatic configure(input logic [31:0] tmo, input logic [15:0] ctr,
                           input logic [15:0] dband, input logic [15:0] fsafe);
    rcm_pkg::reg_idx_t idx [4];
    logic [31:0]       val [4];
    int                i;
    idx = '{rcm_pkg::REG_TIMEOUT, rcm_pkg::REG_CENTER, rcm_pkg::REG_DEADBAND,
            rcm_pkg::REG_FAILSAFE};
    val = '{tmo, 32'(ctr), 32'(dband), 32'(fsafe)};
    drain();
    for (i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      model.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly plausible stick travel, sometimes odd widths and boundary cases
  function automatic logic [31:0] pulse_span();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 65535);
      2: return 32'(model.center) + 32'(model.deadband) + $urandom_range(0, 1);
      3: return 32'(model.center) - 32'(model.deadband) - $urandom_range(0, 1);
      default: return $urandom_range(900, 2100);
    endcase
  endfunction

  function automatic logic [31:0] eval_stamp();
    case ($urandom_range(0, 9))
      0: return cmd_stamp + model.timeout_us;
      1: return cmd_stamp + model.timeout_us + 32'd1;
      2: return $urandom;
      3: return cmd_stamp + $urandom_range(0, 3000);
      default: return stamp + $urandom_range(0, 400);
    endcase
  endfunction

  function automatic logic [15:0] rand_cmd(int lim);
    if ($urandom_range(0, 9) < 3) return 16'($urandom);
    return 16'($urandom_range(0, 2 * lim + 400) - (lim + 200));
  endfunction

  // One frame: a noise item alone, or optional host command, pulses on some channels, then evaluate
  task automatic random_frame();
    int          kind, i;
    logic [31:0] span;
    logic [15:0] thr;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      send_item(noise_item());
      return;
    end
    if (kind == 2) drain();
    if ($urandom_range(0, 2) == 0) begin
      thr = ($urandom_range(0, 9) < 3) ? 16'($urandom) : 16'($urandom_range(4000, 14000));
      send_cmd(stamp, rand_cmd(ANGLE_LIM), rand_cmd(ANGLE_LIM), rand_cmd(YAW_LIM), thr);
    end
    for (i = 0; i < rcm_pkg::NUM_CHANNELS; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        span = pulse_span();
        pulse(2'(i), stamp, span);
        stamp = stamp + span + $urandom_range(0, 300);
      end
    end
    stamp = eval_stamp();
    send_eval(stamp);
  endtask

  task automatic run_phase(input logic [31:0] tmo, input logic [15:0] ctr,
                           input logic [15:0] dband, input logic [15:0] fsafe,
                           input logic s_idle, input logic r_idle, input int hold);
    int target;
    configure(tmo, ctr, dband, fsafe);
    send_idle   = s_idle;
    recv_idle   = r_idle;
    hold_cycles = hold;
    target      = sent + PHASE_ITEMS;
    while (sent < target) random_frame();
  endtask

  // Result sink with random back-pressure and the occasional long hold-off
  initial begin : result_sink
    int         stall;
    drive_set_t got;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = recv_idle ? $urandom_range(0, 8) : 0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      got.roll     = out_if.roll_out;
      got.pitch    = out_if.pitch_out;
      got.thrust   = out_if.thrust_out;
      got.yaw      = out_if.yaw_out;
      got.failsafe = out_if.failsafe_active;
      model.check_drives(got);
    end
  end

  initial begin : stimulus
    pulse_item_t it;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= rcm_pkg::REG_TIMEOUT;
    cfg_wdata          <= '0;
    in_if.valid        <= 1'b0;
    in_if.opcode       <= rcm_pkg::OP_EDGE;
    in_if.channel      <= rcm_pkg::CH_ROLL;
    in_if.level        <= 1'b0;
    in_if.now_us       <= '0;
    in_if.roll_cmd     <= '0;
    in_if.pitch_cmd    <= '0;
    in_if.yaw_rate_cmd <= '0;
    in_if.thrust_cmd   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: evaluate from reset, saturating commands, each mix rule,
    // timeout boundary, timestamp wrap, unused opcode, width extremes
    send_eval(32'd0);
    send_cmd(32'd1000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'd0);
    pulse(rcm_pkg::CH_ROLL, 32'd2000, 32'd2000);
    pulse(rcm_pkg::CH_PITCH, 32'd5000, 32'd1550);
    pulse(rcm_pkg::CH_THRUST, 32'd8000, 32'd1000);
    pulse(rcm_pkg::CH_YAW, 32'hFFFF_FF00, 32'd512);
    send_eval(32'd1000 + rcm_pkg::TIMEOUT_RST);
    send_eval(32'd1001 + rcm_pkg::TIMEOUT_RST);
    send_cmd(32'hFFFF_FFF0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hFFFF);
    pulse(rcm_pkg::CH_ROLL, 32'd10, 32'd1551);
    pulse(rcm_pkg::CH_PITCH, 32'd20, 32'd1449);
    send_eval(32'h10);
    it = noise_item();
    it.opcode = OP_IDLE_CODE;
    send_item(it);
    pulse(rcm_pkg::CH_THRUST, 32'd50, 32'd65535);
    pulse(rcm_pkg::CH_YAW, 32'd100, 32'h1_0000);
    send_eval(32'h50 + rcm_pkg::TIMEOUT_RST);

    // Random phases over several register settings, extremes included
    stamp = 32'h100;
    run_phase(rcm_pkg::TIMEOUT_RST, rcm_pkg::CENTER_RST, rcm_pkg::DEADBAND_RST,
              rcm_pkg::FAILSAFE_RST, 1'b1, 1'b1, 0);
    run_phase(32'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 250);
    run_phase(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 0);
    run_phase($urandom_range(1000, 20000), 16'($urandom_range(1300, 1700)),
              16'($urandom_range(0, 300)), 16'($urandom_range(800, 1000)), 1'b0, 1'b1, 0);
    run_phase($urandom, 16'($urandom), 16'($urandom), 16'($urandom), 1'b1, 1'b1, 0);

    drain();
    repeat (10) @(posedge clk);
    if (model.failures == 0 && model.awaited_drives.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### filelist.f
src/rcm_pkg.sv
src/rcm_if.sv
src/rcm_cmd_prep.sv
src/rcm_core.sv
src/rc_pulse_capture_command_mixer.sv
tb/sv/tb_rc_pulse_capture_command_mixer.sv
